>>> src/cpa_pkg.sv
`timescale 1ns / 1ps

package cpa_pkg;

   // Pool geometry
   localparam int BLOCK_BYTES = 64;
   localparam int BLOCK_COUNT = 16;
   localparam int GUARD_BYTES = 4;
   localparam int REC_BYTES   = BLOCK_BYTES + 2 * GUARD_BYTES;
   localparam int TAIL_START  = GUARD_BYTES + BLOCK_BYTES;
   localparam int GRANT_LIMIT = (BLOCK_COUNT < 16) ? BLOCK_COUNT : 16;

   // Derived widths
   localparam int BLK_W      = $clog2(BLOCK_COUNT);
   localparam int OFF_W      = $clog2(BLOCK_BYTES);
   localparam int DATA_DEPTH = BLOCK_COUNT * BLOCK_BYTES;
   localparam int DATA_AW    = $clog2(DATA_DEPTH);
   localparam int GUARD_W    = 8 * GUARD_BYTES;

   localparam logic [GUARD_W-1:0] GUARD_WORD = 32'hBADD_F00D;
   localparam logic [4:0]         COUNT_MAX  = 5'd31;

   typedef enum logic [2:0] {
      ACT_ALLOC = 3'd0,
      ACT_FREE  = 3'd1,
      ACT_WRITE = 3'd2,
      ACT_READ  = 3'd3,
      ACT_CHECK = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EXHAUSTED = 2'd1,
      ST_CORRUPT   = 2'd2
   } status_type;

endpackage

>>> src/canary_pool_allocator.sv
`timescale 1ns / 1ps

// Guarded fixed-block pool: 16 blocks of 64 data bytes, each framed by a
// head and a tail guard word, plus a used flag per block.
// Command channel: a request transfers at a rising edge with start high and
// busy low (req_action, req_block_index, req_byte_offset, req_write_byte).
// Exactly one result per request: rsp_valid is high for one cycle with
// rsp_status, rsp_granted_block, rsp_read_byte, rsp_broken_count; the
// receiver cannot hold results off and the block never waits on it.
// Path from transfer to result strobe:
//   allocate, unknown action, out-of-range access, data byte write: from idle
//   read byte, guard byte write (read-modify-write of the guard RAM): via RAM read
//   free: guard check first; a broken guard ends it with the result; with
//     intact guards, one data byte zeroed per cycle through the byte-wide data RAM
//   integrity check: one guard RAM read per block, pipelined
// busy drops in the cycle of the result strobe, so the next request may
// transfer at the edge that ends it.
// After reset the block runs a clearing pass that zeroes the data RAM and
// restores all guard words; busy is high during it.
module canary_pool_allocator (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_action,
   input  logic [3:0] req_block_index,
   input  logic [6:0] req_byte_offset,
   input  logic [7:0] req_write_byte,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic [3:0] rsp_granted_block,
   output logic [7:0] rsp_read_byte,
   output logic [4:0] rsp_broken_count
);

   import cpa_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FREE_CHK,
      S_FREE_ZERO,
      S_WR_GUARD,
      S_READ,
      S_CHECK
   } state_type;

   // state and registered outputs
   state_type          state_ff, state_in;
   action_type         act_ff, act_in;
   logic [BLK_W-1:0]   blk_ff, blk_in;
   logic [6:0]         off_ff, off_in;
   logic [7:0]         wb_ff, wb_in;
   logic [DATA_AW-1:0] cnt_ff, cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [4:0]         broken_ff, broken_in;
   logic [BLOCK_COUNT-1:0] used_ff, used_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [3:0]         rsp_granted_ff, rsp_granted_in;
   logic [7:0]         rsp_read_ff, rsp_read_in;
   logic [4:0]         rsp_broken_ff, rsp_broken_in;

   // memory ports
   logic                 data_we;
   logic [DATA_AW-1:0]   data_waddr;
   logic [7:0]           data_wdata;
   logic [DATA_AW-1:0]   data_raddr;
   logic [7:0]           data_rdata;
   logic                 guard_we;
   logic [BLK_W-1:0]     guard_waddr;
   logic [2*GUARD_W-1:0] guard_wdata;
   logic [BLK_W-1:0]     guard_raddr;
   logic [2*GUARD_W-1:0] guard_rdata;

   logic [GUARD_W-1:0] head_rd, tail_rd;
   logic               intact;
   logic               blk_ok, off_ok;
   logic [6:0]         off_rel;
   logic               alloc_found;
   logic [BLK_W-1:0]   alloc_idx;

   assign head_rd = guard_rdata[GUARD_W-1:0];
   assign tail_rd = guard_rdata[2*GUARD_W-1:GUARD_W];
   assign intact  = (head_rd == GUARD_WORD) && (tail_rd == GUARD_WORD);

   assign blk_ok  = (32'(req_block_index) < BLOCK_COUNT);
   assign off_ok  = (32'(req_byte_offset) < REC_BYTES);
   assign off_rel = req_byte_offset - 7'(GUARD_BYTES);

   // lowest free block
   always_comb begin
      alloc_found = 1'b0;
      alloc_idx   = '0;
      for (int i = 0; i < GRANT_LIMIT; i++) begin
         if (!alloc_found && !used_ff[i]) begin
            alloc_found = 1'b1;
            alloc_idx   = BLK_W'(i);
         end
      end
   end

   cpa_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (data_waddr),
      .wr_data (data_wdata),
      .rd_addr (data_raddr),
      .rd_data (data_rdata)
   );

   cpa_ram #(.WIDTH(2 * GUARD_W), .DEPTH(BLOCK_COUNT)) u_guard_ram (
      .clock   (clock),
      .wr_en   (guard_we),
      .wr_addr (guard_waddr),
      .wr_data (guard_wdata),
      .rd_addr (guard_raddr),
      .rd_data (guard_rdata)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      act_in         = act_ff;
      blk_in         = blk_ff;
      off_in         = off_ff;
      wb_in          = wb_ff;
      cnt_in         = cnt_ff;
      chk_vld_in     = 1'b0;
      broken_in      = broken_ff;
      used_in        = used_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = ST_OK;
      rsp_granted_in = '0;
      rsp_read_in    = '0;
      rsp_broken_in  = '0;

      data_we     = 1'b0;
      data_waddr  = {blk_ff, cnt_ff[OFF_W-1:0]};
      data_wdata  = '0;
      data_raddr  = {req_block_index, off_rel[OFF_W-1:0]};
      guard_we    = 1'b0;
      guard_waddr = blk_ff;
      guard_wdata = guard_rdata;
      guard_raddr = req_block_index;

      unique case (state_ff)
         S_CLEAR: begin
            data_we     = 1'b1;
            data_waddr  = cnt_ff;
            guard_we    = 1'b1;
            guard_waddr = cnt_ff[BLK_W-1:0];
            guard_wdata = {GUARD_WORD, GUARD_WORD};
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == DATA_AW'(DATA_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               act_in    = action_type'(req_action);
               blk_in    = req_block_index;
               off_in    = req_byte_offset;
               wb_in     = req_write_byte;
               cnt_in    = '0;
               broken_in = '0;
               unique case (action_type'(req_action))
                  ACT_ALLOC: begin
                     rsp_valid_in = 1'b1;
                     if (alloc_found) begin
                        used_in[alloc_idx] = 1'b1;
                        rsp_granted_in     = 4'(alloc_idx);
                     end else begin
                        rsp_status_in = ST_EXHAUSTED;
                     end
                  end
                  ACT_FREE: begin
                     if (blk_ok) begin
                        state_in = S_FREE_CHK;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_WRITE: begin
                     if (blk_ok && off_ok && (req_byte_offset >= 7'(GUARD_BYTES))
                         && (req_byte_offset < 7'(TAIL_START))) begin
                        // data byte: write straight through
                        data_we      = 1'b1;
                        data_waddr   = {req_block_index, off_rel[OFF_W-1:0]};
                        data_wdata   = req_write_byte;
                        rsp_valid_in = 1'b1;
                     end else if (blk_ok && off_ok) begin
                        state_in = S_WR_GUARD;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_READ: begin
                     if (blk_ok && off_ok) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_CHECK: begin
                     state_in = S_CHECK;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_FREE_CHK: begin
            if (intact) begin
               state_in = S_FREE_ZERO;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_CORRUPT;
               state_in      = S_IDLE;
            end
         end

         S_FREE_ZERO: begin
            data_we = 1'b1;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff[OFF_W-1:0] == OFF_W'(BLOCK_BYTES - 1)) begin
               used_in[blk_ff] = 1'b0;
               rsp_valid_in    = 1'b1;
               state_in        = S_IDLE;
            end
         end

         S_WR_GUARD: begin
            // merge one byte into the head or tail word
            guard_we = 1'b1;
            if (off_ff < 7'(GUARD_BYTES)) begin
               guard_wdata[8*off_ff[1:0] +: 8] = wb_ff;
            end else begin
               guard_wdata[GUARD_W + 8*off_ff[1:0] +: 8] = wb_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_READ: begin
            if (off_ff < 7'(GUARD_BYTES)) begin
               rsp_read_in = head_rd[8*off_ff[1:0] +: 8];
            end else if (off_ff < 7'(TAIL_START)) begin
               rsp_read_in = data_rdata;
            end else begin
               rsp_read_in = tail_rd[8*off_ff[1:0] +: 8];
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end

         S_CHECK: begin
            // issue one guard read per block, evaluate it in the following cycle
            guard_raddr = cnt_ff[BLK_W-1:0];
            if (chk_vld_ff && !intact && (broken_ff < COUNT_MAX)) begin
               broken_in = broken_ff + 1'b1;
            end
            if (cnt_ff == DATA_AW'(BLOCK_COUNT)) begin
               rsp_valid_in  = 1'b1;
               rsp_broken_in = broken_in;
               state_in      = S_IDLE;
            end else begin
               chk_vld_in = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         chk_vld_ff   <= chk_vld_in;
         used_ff      <= used_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff         <= act_in;
      blk_ff         <= blk_in;
      off_ff         <= off_in;
      wb_ff          <= wb_in;
      broken_ff      <= broken_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_read_ff    <= rsp_read_in;
      rsp_broken_ff  <= rsp_broken_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_block = rsp_granted_ff;
   assign rsp_read_byte     = rsp_read_ff;
   assign rsp_broken_count  = rsp_broken_ff;

   // no request transfers during the clearing pass
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLEAR |-> busy)
      else $error("request window open during clearing pass");

   // a granted block is marked used
   a_grant_used: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && act_ff == ACT_ALLOC && rsp_status_ff == ST_OK
      |-> used_ff[rsp_granted_ff[BLK_W-1:0]])
      else $error("granted block not marked used");

   // corruption is only reported by free
   a_corrupt_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ST_CORRUPT |-> act_ff == ACT_FREE)
      else $error("corruption status outside free");

   // a completed zeroing sweep releases the block
   a_free_release: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FREE_ZERO && state_in == S_IDLE |=> !used_ff[$past(blk_ff)])
      else $error("freed block still marked used");

   // count bounded by the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> 32'(rsp_broken_ff) <= BLOCK_COUNT)
      else $error("broken count exceeds pool size");

endmodule

>>> src/cpa_ram.sv
`timescale 1ns / 1ps

module cpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
